// File: hw/rtl/rrtr_pkg.sv
`default_nettype none
package rrtr_pkg;

  localparam int RING_SLOTS = 64;
  localparam int ID_BITS    = 8;
  localparam int SLOT_BITS  = $clog2(RING_SLOTS);
  localparam int CNT_BITS   = $clog2(RING_SLOTS + 1);

  // microprogram steps
  typedef enum logic [3:0] {
    ST_WAIT,
    ST_DISPATCH,
    ST_PREP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_YIELD,
    ST_READ_RUN,
    ST_EMIT,
    ST_HOLD
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_YIELD,
    COND_FULL,
    COND_SHIFT_DONE,
    COND_OUT_FREE
  } cond_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PREP,
    ACT_RD_PREV,
    ACT_WR_SHIFT,
    ACT_WR_NEW,
    ACT_ADVANCE,
    ACT_RD_RUN,
    ACT_EMIT
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    act_t  act;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    act_t act;
    logic idle;
  } ctrl_t;

  // status flags seen by the sequencer
  typedef struct packed {
    logic start;
    logic yield;
    logic full;
    logic shift_done;
    logic out_free;
  } flags_t;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{cond: COND_ALWAYS, target: ST_WAIT, act: ACT_NONE};
    case (s)
      ST_WAIT:     w = '{cond: COND_NO_START,   target: ST_WAIT,     act: ACT_LATCH};
      ST_DISPATCH: w = '{cond: COND_YIELD,      target: ST_YIELD,    act: ACT_NONE};
      ST_PREP:     w = '{cond: COND_FULL,       target: ST_READ_RUN, act: ACT_PREP};
      ST_SHIFT_RD: w = '{cond: COND_SHIFT_DONE, target: ST_INSERT,   act: ACT_RD_PREV};
      ST_SHIFT_WR: w = '{cond: COND_ALWAYS,     target: ST_SHIFT_RD, act: ACT_WR_SHIFT};
      ST_INSERT:   w = '{cond: COND_ALWAYS,     target: ST_READ_RUN, act: ACT_WR_NEW};
      ST_YIELD:    w = '{cond: COND_ALWAYS,     target: ST_READ_RUN, act: ACT_ADVANCE};
      ST_READ_RUN: w = '{cond: COND_NEVER,      target: ST_WAIT,     act: ACT_RD_RUN};
      ST_EMIT:     w = '{cond: COND_OUT_FREE,   target: ST_WAIT,     act: ACT_EMIT};
      ST_HOLD:     w = '{cond: COND_ALWAYS,     target: ST_EMIT,     act: ACT_NONE};
      default:     w = '{cond: COND_ALWAYS,     target: ST_WAIT,     act: ACT_NONE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/round_robin_thread_ring.sv
// channel  signals                             direction  payload
// in       in_valid in_ready                   to block   command, new_thread_id
// out      out_valid out_ready                 from block status, running_id, thread_total
//
// create: each thread behind the running slot is shifted up by one read and one
//   write of the slot ram, stepped by the microprogram
// reset: rst synchronous, active high; ring holds one thread (id 0) running
// stalls: a finished word sits in the output register; the next command is
//   taken meanwhile and its own result waits at the emit step until out frees
`default_nettype none
module round_robin_thread_ring
  import rrtr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                command,
  input  wire logic [ID_BITS-1:0]  new_thread_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     status,
  output logic [ID_BITS-1:0]       running_id,
  output logic [CNT_BITS-1:0]      thread_total
);

  ctrl_t               ctrl;
  flags_t              flags;
  logic                yield;
  logic                full;
  logic                shift_done;
  logic                res_status;
  logic [ID_BITS-1:0]  res_id;
  logic [CNT_BITS-1:0] res_total;

  // sequencer flags: start from the input side, out_free from the output register
  always_comb begin
    flags.start      = in_valid;
    flags.yield      = yield;
    flags.full       = full;
    flags.shift_done = shift_done;
    flags.out_free   = !out_valid || out_ready;
  end

  // commands are taken only at the wait step of the microprogram
  assign in_ready = ctrl.idle;

  rrtr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .flags(flags),
    .ctrl (ctrl)
  );

  rrtr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (command),
    .new_thread_id(new_thread_id),
    .yield        (yield),
    .full         (full),
    .shift_done   (shift_done),
    .res_status   (res_status),
    .res_id       (res_id),
    .res_total    (res_total)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.act == ACT_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_EMIT) begin
      status       <= res_status;
      running_id   <= res_id;
      thread_total <= res_total;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rrtr_ram.sv
`default_nettype none
module rrtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rrtr_seq.sv
`default_nettype none
module rrtr_seq
  import rrtr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire flags_t flags,
  output ctrl_t       ctrl
);

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   take;
  logic   act_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uw = ucode(pc);
    case (uw.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_START:   take = !flags.start;
      COND_YIELD:      take = flags.yield;
      COND_FULL:       take = flags.full;
      COND_SHIFT_DONE: take = flags.shift_done;
      COND_OUT_FREE:   take = flags.out_free;
      default:         take = 1'b1;
    endcase
    // waiting steps only act once their condition lets them go
    act_en = 1'b1;
    if (uw.cond == COND_NO_START) begin
      act_en = flags.start;
    end else if (uw.cond == COND_OUT_FREE) begin
      act_en = flags.out_free;
    end
    pc_next   = take ? uw.target : step_t'(pc + 4'd1);
    ctrl.act  = act_en ? uw.act : ACT_NONE;
    ctrl.idle = (pc == ST_WAIT);
  end

endmodule
`default_nettype wire

// File: hw/rtl/rrtr_dp.sv
`default_nettype none
module rrtr_dp
  import rrtr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_t              ctrl,
  input  wire logic               command,
  input  wire logic [ID_BITS-1:0] new_thread_id,
  output logic                    yield,
  output logic                    full,
  output logic                    shift_done,
  output logic                    res_status,
  output logic [ID_BITS-1:0]      res_id,
  output logic [CNT_BITS-1:0]     res_total
);

  logic                 cmd;
  logic [ID_BITS-1:0]   new_id;
  logic [SLOT_BITS-1:0] idx;
  logic [SLOT_BITS-1:0] running;
  logic [CNT_BITS-1:0]  count;
  logic                 status;
  logic                 rd_zero;

  logic                 we;
  logic [SLOT_BITS-1:0] waddr;
  logic [ID_BITS-1:0]   wdata;
  logic                 re;
  logic [SLOT_BITS-1:0] raddr;
  logic [ID_BITS-1:0]   rdata;
  logic [CNT_BITS-1:0]  run_inc;

  rrtr_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(RING_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    run_inc    = CNT_BITS'(running) + CNT_BITS'(1);
    yield      = cmd;
    full       = (count >= CNT_BITS'(RING_SLOTS));
    shift_done = (CNT_BITS'(idx) <= run_inc);
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    re    = 1'b0;
    raddr = idx - SLOT_BITS'(1);
    case (ctrl.act)
      ACT_RD_PREV: re = 1'b1;
      ACT_WR_SHIFT: we = 1'b1;
      ACT_WR_NEW: begin
        we    = 1'b1;
        waddr = running + SLOT_BITS'(1);
        wdata = new_id;
      end
      ACT_RD_RUN: begin
        re    = 1'b1;
        raddr = running;
      end
      default: ;
    endcase
  end

  // slot 0 is never written: a read of it is forced to zero
  assign res_id     = rd_zero ? '0 : rdata;
  assign res_status = status;
  assign res_total  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= CNT_BITS'(1);
      running <= '0;
    end else begin
      case (ctrl.act)
        ACT_WR_NEW: count <= count + CNT_BITS'(1);
        ACT_ADVANCE: begin
          if (count > CNT_BITS'(1)) begin
            running <= (run_inc == count) ? '0 : SLOT_BITS'(run_inc);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_LATCH: begin
        cmd    <= command;
        new_id <= new_thread_id;
        status <= 1'b0;
      end
      ACT_PREP: begin
        idx    <= SLOT_BITS'(count);
        status <= full;
      end
      ACT_WR_SHIFT: idx <= idx - SLOT_BITS'(1);
      ACT_RD_RUN: rd_zero <= (running == '0);
      default: ;
    endcase
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_BITS'(1)) && (count <= CNT_BITS'(RING_SLOTS)))
    else $error("thread count out of range");

  a_running_in_ring: assert property (@(posedge clk) disable iff (rst)
    CNT_BITS'(running) < count)
    else $error("running slot beyond thread count");

  a_slot0_kept: assert property (@(posedge clk) disable iff (rst)
    we |-> (waddr != '0))
    else $error("write to slot 0");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_WR_NEW) |=> (count == $past(count) + CNT_BITS'(1)))
    else $error("insert did not grow count");
`endif

endmodule
`default_nettype wire
